// ===== hw/rtl/kht_pkg.sv =====
// ----------------------------------------------------------------------------
// kht_pkg
// Shared types and constants for the key hold and search timer.
// ----------------------------------------------------------------------------
package kht_pkg;

  localparam int HELD_SLOTS_DEF = 6;
  localparam int CODE_W         = 8;
  localparam int KEY_W          = 7;
  localparam int TIME_W         = 32;
  localparam int BREAK_BIT      = 7;

  // request travelling down the slot chain
  typedef struct packed {
    logic              valid;
    logic              brk;
    logic [KEY_W-1:0]  key;
    logic [TIME_W-1:0] now;
    logic [TIME_W-1:0] search;
    logic              done;
    logic [TIME_W-1:0] hold;
  } kht_req_t;

endpackage

// ===== hw/rtl/kht_cell.sv =====
// ----------------------------------------------------------------------------
// kht_cell
// One held-key slot. Serves the request passing through and hands it on.
// ----------------------------------------------------------------------------
module kht_cell import kht_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  kht_req_t req_i,
  output kht_req_t req_o
);

  logic              used_r, used_nxt;
  logic [KEY_W-1:0]  key_r, key_nxt;
  logic [TIME_W-1:0] press_r, press_nxt;
  logic [TIME_W-1:0] search_r, search_nxt;
  kht_req_t          req_r, req_nxt;

  always_comb begin
    used_nxt   = used_r;
    key_nxt    = key_r;
    press_nxt  = press_r;
    search_nxt = search_r;
    req_nxt    = req_i;
    if (req_i.valid && !req_i.done) begin
      if (req_i.brk) begin
        if (used_r && (key_r == req_i.key)) begin
          req_nxt.done   = 1'b1;
          req_nxt.hold   = req_i.now - press_r;
          req_nxt.search = search_r;
          used_nxt       = 1'b0;
        end
      end else if (!used_r) begin
        req_nxt.done = 1'b1;
        used_nxt     = 1'b1;
        key_nxt      = req_i.key;
        press_nxt    = req_i.now;
        search_nxt   = req_i.search;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r      <= 1'b0;
      req_r.valid <= 1'b0;
    end else begin
      used_r <= used_nxt;
      req_r  <= req_nxt;
    end
    key_r    <= key_nxt;
    press_r  <= press_nxt;
    search_r <= search_nxt;
  end

  assign req_o = req_r;

endmodule

// ===== hw/rtl/key_hold_and_search_timer.sv =====
// ----------------------------------------------------------------------------
// key_hold_and_search_timer
// Tracks held keys from scancodes and reports hold and search times.
// ----------------------------------------------------------------------------
// A scancode request is taken when start is high and busy is low. A repeat
// of the previous raw scancode is dropped at once and leaves busy low. Any
// other request walks the chain of HELD_SLOTS slot cells, one cell per
// cycle, and keeps busy high until it leaves the last cell, so no new
// request is taken while it is in the chain; a release that finds its key
// drives out_valid for one cycle, the first cycle with busy low again. The
// receiver cannot stall: out_valid marks each result for that single cycle
// only.
module key_hold_and_search_timer import kht_pkg::*; #(
  parameter int HELD_SLOTS = HELD_SLOTS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [CODE_W-1:0] in_scancode,
  input  logic [TIME_W-1:0] in_time_ms,
  output logic              out_valid,
  output logic [KEY_W-1:0]  out_key_code,
  output logic [TIME_W-1:0] out_hold_time,
  output logic [TIME_W-1:0] out_search_time
);

  kht_req_t          chain [HELD_SLOTS+1];
  kht_req_t          inj_r, inj_nxt;
  kht_req_t          tail;
  logic              busy_r, busy_nxt;
  logic [CODE_W-1:0] last_raw_r, last_raw_nxt;
  logic [TIME_W-1:0] last_press_r, last_press_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [KEY_W-1:0]  out_key_r;
  logic [TIME_W-1:0] out_hold_r;
  logic [TIME_W-1:0] out_search_r;
  logic              accept;

  assign chain[0] = inj_r;
  assign tail     = chain[HELD_SLOTS];
  assign accept   = start && !busy_r;

  for (genvar g = 0; g < HELD_SLOTS; g++) begin : g_slot
    kht_cell u_slot (
      .clk   (clk),
      .rst_n (rst_n),
      .req_i (chain[g]),
      .req_o (chain[g+1])
    );
  end

  always_comb begin
    inj_nxt        = inj_r;
    inj_nxt.valid  = 1'b0;
    busy_nxt       = busy_r;
    last_raw_nxt   = last_raw_r;
    last_press_nxt = last_press_r;
    out_valid_nxt  = 1'b0;
    if (accept && (in_scancode != last_raw_r)) begin
      inj_nxt.valid  = 1'b1;
      inj_nxt.brk    = in_scancode[BREAK_BIT];
      inj_nxt.key    = in_scancode[KEY_W-1:0];
      inj_nxt.now    = in_time_ms;
      inj_nxt.search = in_time_ms - last_press_r;
      inj_nxt.done   = 1'b0;
      inj_nxt.hold   = '0;
      last_raw_nxt   = in_scancode;
      busy_nxt       = 1'b1;
    end
    if (tail.valid) begin
      busy_nxt = 1'b0;
      if (tail.done && !tail.brk) begin
        last_press_nxt = tail.now;
      end
      if (tail.done && tail.brk) begin
        out_valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inj_r.valid  <= 1'b0;
      busy_r       <= 1'b0;
      last_raw_r   <= '0;
      last_press_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      inj_r        <= inj_nxt;
      busy_r       <= busy_nxt;
      last_raw_r   <= last_raw_nxt;
      last_press_r <= last_press_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    if (tail.valid) begin
      out_key_r    <= tail.key;
      out_hold_r   <= tail.hold;
      out_search_r <= tail.search;
    end
  end

  assign busy            = busy_r;
  assign out_valid       = out_valid_r;
  assign out_key_code    = out_key_r;
  assign out_hold_time   = out_hold_r;
  assign out_search_time = out_search_r;

endmodule

// ===== test/key_hold_and_search_timer_tb.sv =====
// ----------------------------------------------------------------------------
// key_hold_and_search_timer_tb
// Self-checking bench for the held key table and its hold and search times.
// Scancode requests come from a queue: a directed opening, then random
// press and release sequences with some noise. A bench-side model of the key
// table predicts each release, and the monitor checks every strobed result
// against the oldest prediction.
// ----------------------------------------------------------------------------
module key_hold_and_search_timer_tb;
  import kht_pkg::*;

  typedef struct {
    logic [CODE_W-1:0] code;
    logic [TIME_W-1:0] ms;
  } scan_req_t;

  typedef struct {
    logic [KEY_W-1:0]  key;
    logic [TIME_W-1:0] hold;
    logic [TIME_W-1:0] search;
  } key_release_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [CODE_W-1:0] in_scancode = '0;
  logic [TIME_W-1:0] in_time_ms = '0;
  logic              out_valid;
  logic [KEY_W-1:0]  out_key_code;
  logic [TIME_W-1:0] out_hold_time;
  logic [TIME_W-1:0] out_search_time;

  key_hold_and_search_timer dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_scancode     (in_scancode),
    .in_time_ms      (in_time_ms),
    .out_valid       (out_valid),
    .out_key_code    (out_key_code),
    .out_hold_time   (out_hold_time),
    .out_search_time (out_search_time)
  );

  scan_req_t    scan_q[$];
  key_release_t release_q[$];
  scan_req_t    cur_req;
  key_release_t got_rel;
  logic         have_req = 1'b0;
  int           idle_left = 0;
  int           sent_cnt = 0;
  int           total_req = 0;
  int           err_cnt = 0;

  // bench copy of the held key table
  logic [KEY_W-1:0]  held_key[HELD_SLOTS_DEF] = '{default: '0};
  logic              held_on[HELD_SLOTS_DEF] = '{default: 1'b0};
  logic [TIME_W-1:0] held_at[HELD_SLOTS_DEF] = '{default: '0};
  logic [TIME_W-1:0] held_search[HELD_SLOTS_DEF] = '{default: '0};
  logic [TIME_W-1:0] prev_press = '0;
  logic [CODE_W-1:0] prev_code = '0;

  task automatic track_scancode(input logic [CODE_W-1:0] code,
                                input logic [TIME_W-1:0] now_ms);
    logic [KEY_W-1:0] key;
    key_release_t     rel;
    bit               found;
    key = code[KEY_W-1:0];
    found = 1'b0;
    if (code == prev_code) return;
    if (code[BREAK_BIT]) begin
      for (int i = 0; i < HELD_SLOTS_DEF; i++) begin
        if (!found && held_on[i] && held_key[i] == key) begin
          rel.key = key;
          rel.hold = now_ms - held_at[i];
          rel.search = held_search[i];
          release_q.push_back(rel);
          held_on[i] = 1'b0;
          held_key[i] = '0;
          held_at[i] = '0;
          found = 1'b1;
        end
      end
    end else begin
      for (int i = 0; i < HELD_SLOTS_DEF; i++) begin
        if (!found && !held_on[i]) begin
          held_on[i] = 1'b1;
          held_key[i] = key;
          held_at[i] = now_ms;
          held_search[i] = now_ms - prev_press;
          prev_press = now_ms;
          found = 1'b1;
        end
      end
    end
    prev_code = code;
  endtask

  function automatic void push_scan(input logic [CODE_W-1:0] code,
                                    input logic [TIME_W-1:0] ms);
    scan_req_t r;
    r.code = code;
    r.ms = ms;
    scan_q.push_back(r);
  endfunction

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
  end

  // request queue: directed opening, then random sequences
  initial begin
    logic [KEY_W-1:0]  gen_keys[$];
    logic [TIME_W-1:0] gen_ms;
    logic [CODE_W-1:0] gen_last;
    logic [CODE_W-1:0] code;
    logic [KEY_W-1:0]  key;
    int                r;
    int                idx;
    push_scan(8'h00, 32'd5);                 // repeat of the reset code
    push_scan(8'h1E, 32'd100);
    push_scan(8'h1E, 32'd150);               // repeated raw code
    push_scan(8'h30, 32'hFFFF_FFF0);
    push_scan(8'h1E, 32'h0000_0010);         // same key held twice, time wraps
    push_scan(8'h9E, 32'h0000_0020);
    push_scan(8'h9E, 32'h0000_0030);
    push_scan(8'hAA, 32'h0000_0040);         // release of a key not held
    push_scan(8'h7F, 32'hFFFF_FFFF);
    push_scan(8'h00, 32'h0000_0000);
    push_scan(8'h02, 32'h8000_0000);
    push_scan(8'h03, 32'h8000_0001);
    push_scan(8'h04, 32'h8000_0002);
    push_scan(8'h05, 32'h8000_0003);         // table full, dropped
    push_scan(8'h85, 32'h8000_0004);
    push_scan(8'hFF, 32'h0000_0000);
    push_scan(8'h80, 32'hFFFF_FFFF);
    push_scan(8'hB0, 32'h5555_5555);
    push_scan(8'h82, 32'hAAAA_AAAA);
    push_scan(8'h83, 32'h8000_0001);
    push_scan(8'h84, 32'h7FFF_FFFF);
    push_scan(8'h84, 32'h1234_5678);

    gen_ms = $urandom;
    gen_last = 8'h84;
    for (int n = 0; n < 650; n++) begin
      r = $urandom_range(0, 99);
      case ($urandom_range(0, 19))
        0: gen_ms = $urandom;
        1: gen_ms = 32'hFFFF_FF00 + $urandom_range(0, 255);
        default: gen_ms = gen_ms + $urandom_range(0, 40);
      endcase
      if (r < 10) begin
        code = CODE_W'($urandom_range(0, 255));
        push_scan(code, $urandom);
      end else if (r < 15) begin
        code = gen_last;
        push_scan(code, gen_ms);
      end else if (gen_keys.size() == 0 || (r < 60 && gen_keys.size() < 8)) begin
        if (gen_keys.size() > 0 && $urandom_range(0, 9) == 0) begin
          key = gen_keys[$urandom_range(0, gen_keys.size() - 1)];
        end else begin
          key = KEY_W'($urandom_range(0, 127));
        end
        gen_keys.push_back(key);
        code = {1'b0, key};
        push_scan(code, gen_ms);
      end else begin
        idx = $urandom_range(0, gen_keys.size() - 1);
        code = {1'b1, gen_keys[idx]};
        gen_keys.delete(idx);
        push_scan(code, gen_ms);
      end
      gen_last = code;
    end
    total_req = scan_q.size();

    wait (sent_cnt == total_req);
    while (release_q.size() != 0) @(posedge clk);
    repeat (HELD_SLOTS_DEF + 6) @(posedge clk);
    if (err_cnt == 0) begin
      $display("** key_hold_and_search_timer: PASSED **");
    end else begin
      $display("** key_hold_and_search_timer: FAILED **");
    end
    $finish;
  end

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        track_scancode(in_scancode, in_time_ms);
        have_req = 1'b0;
        sent_cnt++;
      end
      if (idle_left > 0) begin
        idle_left--;
        start <= 1'b0;
      end else if (sent_cnt < total_req - 80 && (sent_cnt / 64) % 3 != 2 &&
                   $urandom_range(0, 9) == 0) begin
        idle_left = $urandom_range(0, 4);
        start <= 1'b0;
      end else begin
        if (!have_req && scan_q.size() > 0) begin
          cur_req = scan_q.pop_front();
          in_scancode <= cur_req.code;
          in_time_ms <= cur_req.ms;
          have_req = 1'b1;
        end
        start <= have_req;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (release_q.size() == 0) begin
        $display("%0t: unexpected result key %h hold %h search %h", $time,
                 out_key_code, out_hold_time, out_search_time);
        err_cnt++;
      end else begin
        got_rel = release_q.pop_front();
        if (out_key_code !== got_rel.key) begin
          $display("%0t: key_code expected %h actual %h", $time, got_rel.key,
                   out_key_code);
          err_cnt++;
        end
        if (out_hold_time !== got_rel.hold) begin
          $display("%0t: hold_time expected %h actual %h", $time, got_rel.hold,
                   out_hold_time);
          err_cnt++;
        end
        if (out_search_time !== got_rel.search) begin
          $display("%0t: search_time expected %h actual %h", $time,
                   got_rel.search, out_search_time);
          err_cnt++;
        end
      end
    end
  end

  initial begin
    #2000000;
    $display("** key_hold_and_search_timer: FAILED **");
    $finish;
  end

endmodule

// ===== key_hold_and_search_timer.f =====
hw/rtl/kht_pkg.sv
hw/rtl/kht_cell.sv
hw/rtl/key_hold_and_search_timer.sv
test/key_hold_and_search_timer_tb.sv
